// ===== src/slu_pkg.sv =====
// Shared types, codes and helper functions for the string literal unescaper.
`default_nettype none

package slu_pkg;

  // Decoder mode: where we are inside the string body.
  typedef enum logic [1:0] {
    MODE_BODY = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_UNI  = 2'd3
  } mode_t;

  // Kind of one result item.
  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_END    = 3'd1,
    KIND_BADCHR = 3'd2,
    KIND_BADESC = 3'd3,
    KIND_BADHEX = 3'd4,
    KIND_BADUNI = 3'd5,
    KIND_BADCP  = 3'd6
  } kind_t;

  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0] CHAR_LOWER_N    = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R    = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T    = 8'h74;
  localparam logic [7:0] CHAR_LOWER_U    = 8'h75;
  localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
  localparam logic [7:0] PRINT_LOW       = 8'h20;
  localparam logic [7:0] PRINT_HIGH      = 8'h7F;

  localparam int unsigned MAX_RESULTS = 3;

  // All results caused by one request. Only the first may be a non-data kind.
  typedef struct packed {
    logic [1:0]       count;
    kind_t            kind;
    logic [2:0][7:0]  bytes;
  } group_t;

  // Hex digit value; bit 4 is set when the byte is a valid hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/slu_decoder.sv =====
// Escape decoder: mode, digit state and the result group for each request.
`default_nettype none

module slu_decoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  output logic                 push,
  output slu_pkg::group_t      grp
);
  import slu_pkg::*;

  mode_t       mode, mode_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] accum, accum_next;
  logic        reject_surrogates;

  logic [4:0]  hv;
  logic [15:0] u;

  assign hv = hex_digit(in_byte);
  assign u  = {accum[11:0], hv[3:0]};

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    accum_next       = accum;
    grp.count        = 2'd0;
    grp.kind         = KIND_DATA;
    grp.bytes        = '0;
    unique case (mode)
      MODE_BODY: begin
        grp.count = 2'd1;
        if (in_byte == CHAR_BACKSLASH) begin
          mode_next = MODE_ESC;
          grp.count = 2'd0;
        end else if (in_byte == CHAR_QUOTE) begin
          grp.kind = KIND_END;
        end else if (in_byte >= PRINT_LOW && in_byte <= PRINT_HIGH) begin
          grp.bytes[0] = in_byte;
        end else begin
          grp.kind = KIND_BADCHR;
        end
      end
      MODE_ESC: begin
        digit_count_next = 2'd0;
        accum_next       = 16'd0;
        if (in_byte == CHAR_LOWER_X) begin
          mode_next = MODE_HEX;
        end else if (in_byte == CHAR_LOWER_U) begin
          mode_next = MODE_UNI;
        end else begin
          mode_next = MODE_BODY;
          grp.count = 2'd1;
          case (in_byte)
            CHAR_LOWER_T: grp.bytes[0] = 8'h09;
            CHAR_LOWER_N: grp.bytes[0] = 8'h0A;
            CHAR_LOWER_R: grp.bytes[0] = 8'h0D;
            CHAR_LOWER_A: grp.bytes[0] = 8'h07;
            CHAR_LOWER_B: grp.bytes[0] = 8'h08;
            CHAR_LOWER_F: grp.bytes[0] = 8'h0C;
            CHAR_ZERO:    grp.bytes[0] = 8'h00;
            CHAR_BACKSLASH, CHAR_QUOTE, CHAR_APOSTROPHE: grp.bytes[0] = in_byte;
            default:      grp.kind = KIND_BADESC;
          endcase
        end
      end
      MODE_HEX: begin
        if (!hv[4]) begin
          mode_next        = MODE_BODY;
          digit_count_next = 2'd0;
          accum_next       = 16'd0;
          grp.count        = 2'd1;
          grp.kind         = KIND_BADHEX;
        end else if (digit_count == 2'd0) begin
          accum_next       = {12'd0, hv[3:0]};
          digit_count_next = 2'd1;
        end else begin
          mode_next        = MODE_BODY;
          digit_count_next = 2'd0;
          accum_next       = 16'd0;
          grp.count        = 2'd1;
          grp.bytes[0]     = {accum[3:0], hv[3:0]};
        end
      end
      MODE_UNI: begin
        if (!hv[4]) begin
          mode_next        = MODE_BODY;
          digit_count_next = 2'd0;
          accum_next       = 16'd0;
          grp.count        = 2'd1;
          grp.kind         = KIND_BADUNI;
        end else if (digit_count != 2'd3) begin
          accum_next       = u;
          digit_count_next = digit_count + 2'd1;
        end else begin
          mode_next        = MODE_BODY;
          digit_count_next = 2'd0;
          accum_next       = 16'd0;
          // Reject a surrogate when enabled; else encode the code point as UTF-8, one to three bytes.
          if (reject_surrogates && u >= 16'hD800 && u <= 16'hDFFF) begin
            grp.count = 2'd1;
            grp.kind  = KIND_BADCP;
          end else if (u < 16'h0080) begin
            grp.count    = 2'd1;
            grp.bytes[0] = u[7:0];
          end else if (u < 16'h0800) begin
            grp.count    = 2'd2;
            grp.bytes[0] = {3'b110, u[10:6]};
            grp.bytes[1] = {2'b10, u[5:0]};
          end else begin
            grp.count    = 2'd3;
            grp.bytes[0] = {4'b1110, u[15:12]};
            grp.bytes[1] = {2'b10, u[11:6]};
            grp.bytes[2] = {2'b10, u[5:0]};
          end
        end
      end
      default: begin
        mode_next = MODE_BODY;
      end
    endcase
  end

  assign push = accept && (grp.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_BODY;
      digit_count       <= 2'd0;
      accum             <= 16'd0;
      reject_surrogates <= 1'b1;
    end else begin
      if (accept) begin
        mode        <= mode_next;
        digit_count <= digit_count_next;
        accum       <= accum_next;
      end
      if (cfg_write) begin
        reject_surrogates <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/slu_out_queue.sv =====
// Two-entry queue of result groups, sent out one result per cycle while out_ready is high.
`default_nettype none

module slu_out_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire slu_pkg::group_t grp,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic [2:0]           kind,
  output logic                 last
);
  import slu_pkg::*;

  group_t      entries [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  logic [1:0]  idx;
  group_t      head;
  logic        pop;

  assign head      = entries[rd_ptr];
  assign full      = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_byte  = head.bytes[idx];
  // Only the first result of a group can carry a non-data kind.
  assign kind      = (idx == 2'd0) ? head.kind : KIND_DATA;
  assign last      = (idx == head.count - 2'd1);
  assign pop       = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/string_literal_unescaper.sv =====
// Top level of the string literal unescaper.
`default_nettype none

// Takes one raw byte of a quoted string body per request and returns the
// unescaped bytes, an end marker on the closing quote, or an error kind. A
// request is taken in every cycle while the two-entry result queue has room;
// each request yields zero to three results (a simple escape yields one byte
// for two requests), and the output side sends one result per cycle while
// out_ready is high, so plain bytes run at one byte per cycle. The surrogate
// check follows reject_surrogates, written through cfg_write; the user must write
// it only while the block is idle, which the block itself does not enforce.
module string_literal_unescaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      kind,
  output logic            last
);
  import slu_pkg::*;

  logic   accept;
  logic   push;
  logic   full;
  group_t grp;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  slu_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .push      (push),
    .grp       (grp)
  );

  slu_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .grp       (grp),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

`default_nettype wire
